FILE: rtl/lzss_absolute_window_decoder_macros.svh
// Assertion macros for the LZSS absolute-window decoder.
// Expects clk and rst in the scope where a macro is used.
`ifndef LZSS_ABSOLUTE_WINDOW_DECODER_MACROS_SVH
`define LZSS_ABSOLUTE_WINDOW_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LZSSAW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZSSAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lzssaw_pkg.sv
// Shared constants and types for the LZSS absolute-window decoder.
// No dependencies; imported by the interfaces, the top module, lzssaw_parse and lzssaw_oq.
`timescale 1ns / 1ps

package lzssaw_pkg;

  localparam int LIT_BITS   = 8;
  localparam int LEN_BITS   = 4;
  localparam int LEN_BIAS   = 2;
  localparam int LEN_MAX    = (1 << LEN_BITS) - 1 + LEN_BIAS;
  localparam int REM_W      = $clog2(LEN_MAX + 1);
  localparam int CNT_W      = 48;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_RUN    = 3'd0;
  localparam status_t ST_END    = 3'd1;
  localparam status_t ST_BADREF = 3'd2;
  localparam status_t ST_LIMIT  = 3'd3;
  localparam status_t ST_TRUNC  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 1'd1;

  // bit-serial parser control
  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } pcmd_t;

  // parser events; all but empty are valid only in a shift cycle
  typedef struct packed {
    logic lit_done;
    logic pos_done;
    logic copy_done;
    logic byte_done;
    logic empty;
  } pflags_t;

  // output queue commands
  typedef struct packed {
    logic                push_byte;
    logic [LIT_BITS-1:0] data;
    logic                finish;
    status_t             ev;
  } oq_cmd_t;

  typedef struct packed {
    logic free;
    logic hold_valid;
  } oq_stat_t;

endpackage

FILE: rtl/lzssaw_in_if.sv
// Input channel of the decoder: one compressed byte per transaction.
// Depends on lzssaw_pkg.
`timescale 1ns / 1ps

interface lzssaw_in_if import lzssaw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LIT_BITS-1:0] in_byte;
  logic                first_in_stream;
  logic                last_in_stream;

  modport source (output valid, in_byte, first_in_stream, last_in_stream, input ready);
  modport sink   (input valid, in_byte, first_in_stream, last_in_stream, output ready);
endinterface

FILE: rtl/lzssaw_out_if.sv
// Output channel of the decoder: one decoded byte or status per transaction.
// Depends on lzssaw_pkg.
`timescale 1ns / 1ps

interface lzssaw_out_if import lzssaw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LIT_BITS-1:0] out_byte;
  logic                byte_valid;
  status_t             status;
  logic                last;

  modport source (output valid, out_byte, byte_valid, status, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, status, last, output ready);
endinterface

FILE: rtl/lzss_absolute_window_decoder.sv
// LZSS decoder with absolute ring positions: sequencer, window RAM and counters.
// Depends on lzssaw_pkg, lzssaw_in_if, lzssaw_out_if, lzssaw_ram, lzssaw_parse,
// lzssaw_oq and the assertion macro header.
`timescale 1ns / 1ps
`include "lzss_absolute_window_decoder_macros.svh"

// One compressed byte is taken per transaction, and its bits are parsed one per
// clock while no token is being checked or written out. A byte passes the accept
// state, the bit state and a closing state; each completed literal or copy token
// adds a state for the output-limit check, and every decoded byte then takes a
// read and a write state because the window is a single port RAM that is read and
// then written for each byte (a literal needs only the write). Copies are at most
// 17 bytes long. The decoder works on one input byte at a time and accepts the
// next one once the previous one is fully handled; the newest decoded byte is
// held back so that the end status and last mark land on it. Output back-pressure
// stalls the sequencer. The window is not cleared by reset or by first_in_stream;
// a valid stream never reads unwritten entries.
module lzss_absolute_window_decoder import lzssaw_pkg::*; #(
  parameter int WINDOW_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lzssaw_in_if.sink             din,
  lzssaw_out_if.source          dout
);

  localparam int TOK_W = WINDOW_BITS + LEN_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BIT   = 6'b000010,
    S_CHECK = 6'b000100,
    S_READ  = 6'b001000,
    S_WRITE = 6'b010000,
    S_END   = 6'b100000
  } state_t;

  state_t                state, state_next;
  logic [WINDOW_BITS-1:0] wp;
  logic                  wrapped;
  logic [CNT_W-1:0]      out_cnt;
  logic                  stopped;
  logic                  limit_en;
  logic [CNT_W-1:0]      limit;
  status_t               ev;
  logic                  last_in;
  logic                  is_lit;
  logic [LIT_BITS-1:0]   lit;
  logic [WINDOW_BITS-1:0] rd_ptr;
  logic [REM_W-1:0]      rem;

  pcmd_t                 pcmd;
  pflags_t               pf;
  logic [TOK_W-1:0]      tok_n;
  oq_cmd_t               ocmd;
  oq_stat_t              ostat;

  logic                  ram_we, ram_re;
  logic [WINDOW_BITS-1:0] ram_addr;
  logic [LIT_BITS-1:0]   ram_rdata;
  logic [LIT_BITS-1:0]   wr_data;

  logic [WINDOW_BITS-1:0] pos_n;
  logic                  bad_ref;
  status_t               ev_ref;
  logic                  over;
  logic                  wr_go;
  status_t               ev_fin;
  logic                  end_go;
  logic                  in_acc;

  lzssaw_parse #(.WINDOW_BITS(WINDOW_BITS)) u_parse (
    .clk      (clk),
    .rst      (rst),
    .cmd      (pcmd),
    .in_byte  (din.in_byte),
    .flags    (pf),
    .tok_next (tok_n)
  );

  lzssaw_ram #(.WIDTH(LIT_BITS), .DEPTH(1 << WINDOW_BITS)) u_window (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (wr_data),
    .rdata (ram_rdata)
  );

  lzssaw_oq u_oq (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ocmd),
    .stat (ostat),
    .dout (dout)
  );

  assign din.ready = (state == S_IDLE);
  assign in_acc    = din.valid && din.ready;

  assign pos_n   = tok_n[WINDOW_BITS-1:0];
  assign bad_ref = (pos_n == '0) || (!wrapped && pos_n >= wp);
  assign ev_ref  = (pos_n == '0) ? ST_END : ST_BADREF;
  assign over    = limit_en &&
                   (({1'b0, out_cnt} + (CNT_W + 1)'(rem)) > {1'b0, limit});
  assign wr_data = is_lit ? lit : ram_rdata;
  // the held byte must move out before a new one replaces it
  assign wr_go   = !ostat.hold_valid || ostat.free;
  assign ev_fin  = (ev == ST_RUN && !stopped && last_in) ? ST_TRUNC : ev;
  assign end_go  = !(ostat.hold_valid || ev_fin != ST_RUN) || ostat.free;

  always_comb begin
    pcmd.load  = in_acc;
    pcmd.shift = (state == S_BIT);
    pcmd.clear = (in_acc && din.first_in_stream) ||
                 (state == S_BIT && (pf.lit_done || pf.copy_done ||
                                     (pf.pos_done && bad_ref))) ||
                 (state == S_END && end_go && ev_fin == ST_TRUNC);

    ram_we   = (state == S_WRITE) && wr_go;
    ram_re   = (state == S_READ);
    ram_addr = (state == S_WRITE) ? wp : rd_ptr;

    ocmd.push_byte = ram_we;
    ocmd.data      = wr_data;
    ocmd.finish    = (state == S_END) && end_go;
    ocmd.ev        = ev_fin;

    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && (din.first_in_stream || !stopped)) begin
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        if (pf.lit_done || pf.copy_done) begin
          state_next = S_CHECK;
        end else if ((pf.pos_done && bad_ref) || pf.byte_done) begin
          state_next = S_END;
        end
      end
      S_CHECK: begin
        if (over) begin
          state_next = S_END;
        end else if (is_lit) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (wr_go) begin
          if (rem != REM_W'(1)) begin
            state_next = S_READ;
          end else if (pf.empty) begin
            state_next = S_END;
          end else begin
            state_next = S_BIT;
          end
        end
      end
      S_END: begin
        if (end_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= WINDOW_BITS'(1);
      wrapped  <= 1'b0;
      out_cnt  <= '0;
      stopped  <= 1'b0;
      limit_en <= 1'b0;
      limit    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIMIT_EN: limit_en <= cfg_data[0];
          CFG_LIMIT:    limit    <= cfg_data[CNT_W-1:0];
          default:      ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            ev      <= ST_RUN;
            last_in <= din.last_in_stream;
            if (din.first_in_stream) begin
              wp      <= WINDOW_BITS'(1);
              wrapped <= 1'b0;
              out_cnt <= '0;
              stopped <= 1'b0;
            end
          end
        end
        S_BIT: begin
          if (pf.lit_done) begin
            lit    <= tok_n[LIT_BITS-1:0];
            rem    <= REM_W'(1);
            is_lit <= 1'b1;
          end else if (pf.copy_done) begin
            rd_ptr <= tok_n[TOK_W-1:LEN_BITS];
            rem    <= REM_W'(tok_n[LEN_BITS-1:0]) + REM_W'(LEN_BIAS);
            is_lit <= 1'b0;
          end else if (pf.pos_done && bad_ref) begin
            ev      <= ev_ref;
            stopped <= 1'b1;
          end
        end
        S_CHECK: begin
          if (over) begin
            ev      <= ST_LIMIT;
            stopped <= 1'b1;
          end
        end
        S_WRITE: begin
          if (wr_go) begin
            wp      <= wp + WINDOW_BITS'(1);
            if (wp == '1) begin
              wrapped <= 1'b1;
            end
            out_cnt <= out_cnt + CNT_W'(1);
            rd_ptr  <= rd_ptr + WINDOW_BITS'(1);
            rem     <= rem - REM_W'(1);
          end
        end
        S_END: begin
          if (end_go && ev_fin == ST_TRUNC) begin
            stopped <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `LZSSAW_ASSERT_NOW(a_hold_drain, ram_we && ostat.hold_valid, ostat.free,
    "held byte overwritten while output register full")
  `LZSSAW_ASSERT_NOW(a_rem_live, state == S_READ || state == S_WRITE, rem != '0,
    "copy running with zero bytes remaining")
  `LZSSAW_ASSERT_NEXT(a_wrap_sticky, wrapped && !(in_acc && din.first_in_stream),
    wrapped, "wrap flag cleared without stream restart")
  `LZSSAW_ASSERT_NOW(a_status_only, dout.valid && !dout.byte_valid,
    dout.last && dout.status != ST_RUN, "empty result without final status")

endmodule

FILE: rtl/lzssaw_ram.sv
// Generic single-port RAM, registered read, read-enable gated.
// No dependencies.
`timescale 1ns / 1ps

module lzssaw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/lzssaw_parse.sv
// Bit-serial token parser: shifts the input byte out MSB first and builds tokens.
// Depends on lzssaw_pkg.
`timescale 1ns / 1ps

module lzssaw_parse import lzssaw_pkg::*; #(
  parameter int WINDOW_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pcmd_t                           cmd,
  input  logic [LIT_BITS-1:0]             in_byte,
  output pflags_t                         flags,
  output logic [WINDOW_BITS+LEN_BITS-1:0] tok_next
);

  localparam int TOK_W  = WINDOW_BITS + LEN_BITS;
  localparam int TCNT_W = $clog2(TOK_W + 1);
  localparam int BL_W   = $clog2(LIT_BITS + 1);

  logic [LIT_BITS-1:0] sbyte;
  logic [BL_W-1:0]     bleft;
  logic                tflag;
  logic [TOK_W-1:0]    tok;
  logic [TCNT_W-1:0]   tcnt;
  logic                cur_bit;

  assign cur_bit  = sbyte[LIT_BITS-1];
  assign tok_next = {tok[TOK_W-2:0], cur_bit};

  // tcnt counts bits already taken, flag included
  always_comb begin
    flags.lit_done  = cmd.shift && tcnt != '0 && tflag && tcnt == TCNT_W'(LIT_BITS);
    flags.pos_done  = cmd.shift && tcnt != '0 && !tflag && tcnt == TCNT_W'(WINDOW_BITS);
    flags.copy_done = cmd.shift && tcnt != '0 && !tflag && tcnt == TCNT_W'(TOK_W);
    flags.byte_done = cmd.shift && bleft == BL_W'(1);
    flags.empty     = bleft == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bleft <= '0;
      tcnt  <= '0;
      tflag <= 1'b0;
      tok   <= '0;
    end else begin
      if (cmd.load) begin
        sbyte <= in_byte;
        bleft <= BL_W'(LIT_BITS);
      end else if (cmd.shift) begin
        sbyte <= {sbyte[LIT_BITS-2:0], 1'b0};
        bleft <= bleft - BL_W'(1);
      end
      if (cmd.clear) begin
        tcnt <= '0;
        tok  <= '0;
      end else if (cmd.shift) begin
        if (tcnt == '0) begin
          tflag <= cur_bit;
        end
        tok  <= tok_next;
        tcnt <= tcnt + TCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/lzssaw_oq.sv
// Output queue: one held-back result plus the output register.
// Holding the newest byte lets the end-of-byte status and last mark land on it.
// Depends on lzssaw_pkg and lzssaw_out_if.
`timescale 1ns / 1ps

module lzssaw_oq import lzssaw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  oq_cmd_t             cmd,
  output oq_stat_t            stat,
  lzssaw_out_if.source        dout
);

  logic                hold_valid;
  logic [LIT_BITS-1:0] hold_byte;
  logic                out_valid;
  logic [LIT_BITS-1:0] out_byte;
  logic                out_bv;
  status_t             out_status;
  logic                out_last;
  logic                load_out;

  assign stat.free       = !out_valid || dout.ready;
  assign stat.hold_valid = hold_valid;

  assign dout.valid      = out_valid;
  assign dout.out_byte   = out_byte;
  assign dout.byte_valid = out_bv;
  assign dout.status     = out_status;
  assign dout.last       = out_last;

  assign load_out = (cmd.push_byte && hold_valid) ||
                    (cmd.finish && (hold_valid || cmd.ev != ST_RUN));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.push_byte) begin
        if (hold_valid) begin
          out_byte   <= hold_byte;
          out_bv     <= 1'b1;
          out_status <= ST_RUN;
          out_last   <= 1'b0;
        end
        hold_byte  <= cmd.data;
        hold_valid <= 1'b1;
      end else if (cmd.finish) begin
        if (hold_valid) begin
          out_byte   <= hold_byte;
          out_bv     <= 1'b1;
          out_status <= cmd.ev;
          out_last   <= 1'b1;
        end else if (cmd.ev != ST_RUN) begin
          out_byte   <= '0;
          out_bv     <= 1'b0;
          out_status <= cmd.ev;
          out_last   <= 1'b1;
        end
        hold_valid <= 1'b0;
      end
    end
  end

endmodule
